[sv/cbm_pkg.sv]
`default_nettype none
package cbm_pkg;

    localparam int PRG_WINDOWS = 3;
    localparam int CHR_WINDOWS = 8;

    typedef logic [1:0]  op_t;
    typedef logic [15:0] addr_t;
    typedef logic [7:0]  byte_t;
    typedef logic [4:0]  prg_bank_t;

    localparam op_t OP_CPU_WRITE = 2'd0;
    localparam op_t OP_CPU_TICK  = 2'd1;
    localparam op_t OP_CPU_XLATE = 2'd2;
    localparam op_t OP_PPU_XLATE = 2'd3;

    // Register groups decoded from address bits 14..12 of a write at 0x8000 and up
    localparam logic [2:0] GRP_RELOAD_0 = 3'd0;
    localparam logic [2:0] GRP_RELOAD_1 = 3'd1;
    localparam logic [2:0] GRP_RELOAD_2 = 3'd2;
    localparam logic [2:0] GRP_RELOAD_3 = 3'd3;
    localparam logic [2:0] GRP_IRQ_CTRL = 3'd4;
    localparam logic [2:0] GRP_IRQ_ACK  = 3'd5;
    localparam logic [2:0] GRP_SELECT   = 3'd6;
    localparam logic [2:0] GRP_BANK     = 3'd7;

    // Targets of a bank write, by address bits 11..10
    localparam logic [1:0] BW_PRG_HIGH = 2'b00;
    localparam logic [1:0] BW_NONE     = 2'b01;
    localparam logic [1:0] BW_MIRROR   = 2'b10;
    localparam logic [1:0] BW_CHR      = 2'b11;

    // Select register low nibble codes
    localparam logic [3:0] SEL_PRG_0 = 4'd1;
    localparam logic [3:0] SEL_PRG_1 = 4'd2;
    localparam logic [3:0] SEL_PRG_2 = 4'd3;
    localparam logic [3:0] SEL_WRAM  = 4'd4;

    typedef struct packed {
        logic [PRG_WINDOWS-1:0][4:0] prg;
        logic [CHR_WINDOWS-1:0][7:0] chr;
        logic [7:0]                  wram;
    } bank_state_t;

    typedef struct packed {
        logic irq_pending;
        logic mirror_vertical;
    } status_t;

endpackage
`default_nettype wire

[sv/cbm_item_if.sv]
`default_nettype none
interface cbm_item_if;
    logic            valid;
    logic            ready;
    cbm_pkg::op_t    op;
    cbm_pkg::addr_t  address;
    cbm_pkg::byte_t  data;

    modport source (output valid, output op, output address, output data, input ready);
    modport sink (input valid, input op, input address, input data, output ready);
endinterface
`default_nettype wire

[sv/cbm_result_if.sv]
`default_nettype none
interface cbm_result_if;
    logic           valid;
    logic           ready;
    logic           irq_line;
    cbm_pkg::byte_t mapped_bank;
    logic           mapped_valid;
    logic           mirroring_vertical;

    modport source (
        output valid, output irq_line, output mapped_bank, output mapped_valid,
        output mirroring_vertical, input ready
    );
    modport sink (
        input valid, input irq_line, input mapped_bank, input mapped_valid,
        input mirroring_vertical, output ready
    );
endinterface
`default_nettype wire

[sv/cartridge_bank_mapper_with_irq_counter_core.sv]
// Cartridge bank mapper with a CPU-cycle interrupt counter.
// item channel: one word per CPU cycle: a CPU write (op 0), a cycle tick
//   (op 1), a CPU address translate (op 2) or a PPU address translate (op 3).
// result channel: exactly one word per item: the interrupt line and
//   mirroring as they stand after the item, plus the bank and hit flag of
//   a translate query (zero for writes and ticks).
// cfg_we/cfg_data: wram_present; the user must write it only while the
//   block is idle (the block does not enforce this). Timing: the input
//   register holds an accepted item, the result register its outcome.
//   Throughput: one item per cycle while result.ready stays high; the write
//   decode, counter step and translate all fit between the two registers.
// Stall: when result.ready is low the result register holds its word and
//   the input register holds one more; item.ready falls only once both
//   are full, and rises again in the cycle the result is taken.
// Reset: PRG windows 0,1,2, all other banks, mirroring, counter, reload
//   and interrupt state zero, wram_present one, both stages empty.
`default_nettype none
module cartridge_bank_mapper_with_irq_counter_core
#(
    parameter int PRG_BANK_COUNT = 32
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_data,
    cbm_item_if.sink            item,
    cbm_result_if.source        result
);

    logic           wram_present_reg;
    logic           in_valid_reg;
    cbm_pkg::op_t   in_op_reg;
    cbm_pkg::addr_t in_addr_reg;
    cbm_pkg::byte_t in_data_reg;
    logic           out_valid_reg;
    logic           out_irq_reg;
    cbm_pkg::byte_t out_bank_reg;
    logic           out_hit_reg;
    logic           out_mirror_reg;

    logic                 advance;
    cbm_pkg::bank_state_t banks;
    cbm_pkg::status_t     status_next;
    cbm_pkg::byte_t       xl_bank;
    logic                 xl_valid;

    // Move the held word forward whenever the result slot is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    cbm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .op          (in_op_reg),
        .address     (in_addr_reg),
        .data        (in_data_reg),
        .banks       (banks),
        .status_next (status_next)
    );

    cbm_xlate #(
        .PRG_BANK_COUNT (PRG_BANK_COUNT)
    ) u_xlate (
        .op           (in_op_reg),
        .address      (in_addr_reg),
        .wram_present (wram_present_reg),
        .banks        (banks),
        .mapped_bank  (xl_bank),
        .mapped_valid (xl_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wram_present_reg <= 1'b1;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wram_present_reg <= cfg_data;
            end
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_op_reg   <= item.op;
            in_addr_reg <= item.address;
            in_data_reg <= item.data;
        end
        if (advance)
        begin
            out_irq_reg    <= status_next.irq_pending;
            out_bank_reg   <= xl_bank;
            out_hit_reg    <= xl_valid;
            out_mirror_reg <= status_next.mirror_vertical;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.irq_line           = out_irq_reg;
    assign result.mapped_bank        = out_bank_reg;
    assign result.mapped_valid       = out_hit_reg;
    assign result.mirroring_vertical = out_mirror_reg;

endmodule
`default_nettype wire

[sv/cbm_regs.sv]
`default_nettype none
module cbm_regs
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire cbm_pkg::op_t          op,
    input  wire cbm_pkg::addr_t        address,
    input  wire cbm_pkg::byte_t        data,
    output cbm_pkg::bank_state_t       banks,
    output cbm_pkg::status_t           status_next
);

    cbm_pkg::bank_state_t bank_reg;
    cbm_pkg::bank_state_t bank_next;
    logic        mirror_reg;
    logic        mirror_next;
    logic [7:0]  select_reg;
    logic [7:0]  select_next;
    logic [15:0] reload_reg;
    logic [15:0] reload_next;
    logic [15:0] counter_reg;
    logic [15:0] counter_next;
    logic        enabled_reg;
    logic        enabled_next;
    logic        pending_reg;
    logic        pending_next;

    always_comb
    begin
        bank_next    = bank_reg;
        mirror_next  = mirror_reg;
        select_next  = select_reg;
        reload_next  = reload_reg;
        counter_next = counter_reg;
        enabled_next = enabled_reg;
        pending_next = pending_reg;

        if (en && op == cbm_pkg::OP_CPU_WRITE && address[15])
        begin
            case (address[14:12])
                cbm_pkg::GRP_RELOAD_0: reload_next[3:0]   = data[3:0];
                cbm_pkg::GRP_RELOAD_1: reload_next[7:4]   = data[3:0];
                cbm_pkg::GRP_RELOAD_2: reload_next[11:8]  = data[3:0];
                cbm_pkg::GRP_RELOAD_3: reload_next[15:12] = data[3:0];
                cbm_pkg::GRP_IRQ_CTRL:
                begin
                    enabled_next = (data[3:0] != 4'd0);
                    if (enabled_next)
                    begin
                        counter_next = reload_reg;
                    end
                    pending_next = 1'b0;
                end
                cbm_pkg::GRP_IRQ_ACK: pending_next = 1'b0;
                cbm_pkg::GRP_SELECT:  select_next  = data;
                cbm_pkg::GRP_BANK:
                begin
                    case (select_reg[3:0])
                        cbm_pkg::SEL_PRG_0: bank_next.prg[0][3:0] = data[3:0];
                        cbm_pkg::SEL_PRG_1: bank_next.prg[1][3:0] = data[3:0];
                        cbm_pkg::SEL_PRG_2: bank_next.prg[2][3:0] = data[3:0];
                        cbm_pkg::SEL_WRAM:  bank_next.wram        = data;
                        default: ;
                    endcase
                    case (address[11:10])
                        cbm_pkg::BW_PRG_HIGH:
                        begin
                            if (address[1:0] != 2'd3)
                            begin
                                bank_next.prg[address[1:0]][4] = data[4];
                            end
                        end
                        cbm_pkg::BW_MIRROR: mirror_next = data[0];
                        cbm_pkg::BW_CHR:    bank_next.chr[address[2:0]] = data;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        else if (en && op == cbm_pkg::OP_CPU_TICK && enabled_reg)
        begin
            // Wrap from all ones: reload and raise the interrupt
            if (counter_reg == 16'hFFFF)
            begin
                counter_next = reload_reg;
                pending_next = 1'b1;
            end
            else
            begin
                counter_next = counter_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg.prg  <= {5'd2, 5'd1, 5'd0};
            bank_reg.chr  <= '0;
            bank_reg.wram <= '0;
            mirror_reg    <= 1'b0;
            select_reg    <= '0;
            reload_reg    <= '0;
            counter_reg   <= '0;
            enabled_reg   <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            bank_reg    <= bank_next;
            mirror_reg  <= mirror_next;
            select_reg  <= select_next;
            reload_reg  <= reload_next;
            counter_reg <= counter_next;
            enabled_reg <= enabled_next;
            pending_reg <= pending_next;
        end
    end

    assign banks                       = bank_reg;
    assign status_next.irq_pending     = pending_next;
    assign status_next.mirror_vertical = mirror_next;

endmodule
`default_nettype wire

[sv/cbm_xlate.sv]
`default_nettype none
module cbm_xlate
#(
    parameter int PRG_BANK_COUNT = 32
)
(
    input  wire cbm_pkg::op_t          op,
    input  wire cbm_pkg::addr_t        address,
    input  wire logic                  wram_present,
    input  wire cbm_pkg::bank_state_t  banks,
    output cbm_pkg::byte_t             mapped_bank,
    output logic                       mapped_valid
);

    localparam int PRG_LUT_DEPTH  = 32;
    localparam int WRAM_LUT_DEPTH = 256;

    // Bank number modulo the ROM size, folded at elaboration
    cbm_pkg::byte_t prg_mod  [PRG_LUT_DEPTH];
    cbm_pkg::byte_t wram_mod [WRAM_LUT_DEPTH];

    for (genvar i = 0; i < PRG_LUT_DEPTH; i++)
    begin : g_prg_mod
        assign prg_mod[i] = 8'(i % PRG_BANK_COUNT);
    end

    for (genvar i = 0; i < WRAM_LUT_DEPTH; i++)
    begin : g_wram_mod
        assign wram_mod[i] = 8'(i % PRG_BANK_COUNT);
    end

    always_comb
    begin
        mapped_bank  = '0;
        mapped_valid = 1'b0;
        case (op)
            cbm_pkg::OP_CPU_XLATE:
            begin
                if (address[15:13] == 3'b011)
                begin
                    mapped_valid = 1'b1;
                    mapped_bank  = wram_present ? 8'd0 : wram_mod[banks.wram];
                end
                else if (address[15:13] == 3'b111)
                begin
                    mapped_valid = 1'b1;
                    mapped_bank  = 8'(PRG_BANK_COUNT - 1);
                end
                else if (address[15])
                begin
                    mapped_valid = 1'b1;
                    mapped_bank  = prg_mod[banks.prg[address[14:13]]];
                end
            end
            cbm_pkg::OP_PPU_XLATE:
            begin
                if (address[15:13] == 3'b000)
                begin
                    mapped_valid = 1'b1;
                    mapped_bank  = banks.chr[address[12:10]];
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
